// File: src/vcfc_pkg.sv
// vcfc_pkg: shared types and constants for the vertex component float convert block
// no dependencies
package vcfc_pkg;
	localparam int COMPONENTS = 16;
	localparam int IDX_W = 4;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FLOAT_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_MASK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INT_MASK = 2'd2;
	localparam logic [31:0] INT_MAX_BITS = 32'h7FFF_FFFF;
	localparam logic [31:0] INT_MIN_BITS = 32'h8000_0000;
	localparam logic [4:0] FIXED_SCALE = 5'd16;

	typedef struct packed {
		logic [IDX_W-1:0] component_index;
		logic [31:0] value_bits;
	} vcfc_in_t;

	typedef struct packed {
		logic [31:0] result_bits;
		logic out_of_range;
	} vcfc_out_t;
endpackage

// File: src/vcfc_if.sv
// vcfc_if: valid/ready channel carrying a payload struct
// depends on vcfc_pkg
interface vcfc_in_if import vcfc_pkg::*; ();
	logic valid;
	logic ready;
	vcfc_in_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface vcfc_out_if import vcfc_pkg::*; ();
	logic valid;
	logic ready;
	vcfc_out_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: src/vertex_component_float_convert_core.sv
// vertex_component_float_convert_core: per-component float to int32 / 16.16 converter
// depends on vcfc_pkg and the channel interfaces in vcfc_if.sv
// Takes one component per cycle with full throughput unless the sink stalls; each item passes
// through four registers: stage 1 decodes mode and operand, stage 2 shifts the significand,
// stage 3 saturates and negates, and an output register feeds the sink.
// A stall freezes all stages together. Mask writes take effect on items accepted later.
module vertex_component_float_convert_core import vcfc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	vcfc_in_if.sink in_ch,
	vcfc_out_if.source out_ch
);
	logic [CFG_W-1:0] float_mask_q, fixed_mask_q, int_mask_q;
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv;

	// stage 1 regs
	logic conv_s1, sign_s1, nan_s1, inf_s1, zero_s1;
	logic [23:0] sig_s1;
	logic signed [9:0] e_s1;
	logic [31:0] raw_s1;
	// stage 2 regs
	logic conv_s2, sign_s2, sat_s2, nan_s2, inf_s2;
	logic [31:0] mag_s2, raw_s2;
	// stage 3 regs
	vcfc_out_t res_s3;
	vcfc_out_t res_s4;

	assign adv = !v_s4 || out_ch.ready;
	assign in_ch.ready = adv;
	assign out_ch.valid = v_s4;
	assign out_ch.payload = res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			float_mask_q <= '0;
			fixed_mask_q <= '0;
			int_mask_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FLOAT_MASK: float_mask_q <= cfg_data;
				REG_FIXED_MASK: fixed_mask_q <= cfg_data;
				REG_INT_MASK: int_mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: mode select and field decode
	logic [IDX_W-1:0] idx;
	logic [31:0] w;
	logic is_int, is_fix;
	logic [7:0] ex;
	assign idx = in_ch.payload.component_index;
	assign w = in_ch.payload.value_bits;
	assign ex = w[30:23];
	assign is_int = int_mask_q[idx];
	assign is_fix = fixed_mask_q[idx];
	logic unused_float;
	assign unused_float = ^float_mask_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			conv_s1 <= is_int || is_fix || (unused_float & 1'b0);
			sign_s1 <= w[31];
			nan_s1 <= (ex == 8'hFF) && (w[22:0] != '0);
			inf_s1 <= (ex == 8'hFF) && (w[22:0] == '0);
			zero_s1 <= (ex == 8'h00) && (w[22:0] == '0);
			sig_s1 <= {ex != 8'h00, w[22:0]};
			e_s1 <= ((ex == 8'h00) ? 10'sd1 : $signed({2'b00, ex}))
				- 10'sd150 + (is_int ? 10'sd0 : $signed({5'b0, FIXED_SCALE}));
			raw_s1 <= w;
		end
	end

	// stage 2: shift significand
	logic [31:0] mag_c;
	logic sat_c;
	logic [5:0] rs;
	logic [3:0] ls;
	always_comb begin
		mag_c = '0;
		sat_c = 1'b0;
		rs = '0;
		ls = '0;
		if (zero_s1) begin
			mag_c = '0;
		end else if (e_s1 >= 10'sd9) begin
			sat_c = 1'b1;
		end else if (e_s1 >= 10'sd0) begin
			ls = e_s1[3:0];
			{sat_c, mag_c} = {9'b0, sig_s1} << ls;
		end else if (e_s1 > -10'sd32) begin
			rs = 6'(-e_s1);
			mag_c = {8'b0, sig_s1} >> rs;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			conv_s2 <= conv_s1;
			sign_s2 <= sign_s1;
			nan_s2 <= nan_s1;
			inf_s2 <= inf_s1;
			sat_s2 <= sat_c;
			mag_s2 <= mag_c;
			raw_s2 <= raw_s1;
		end
	end

	// stage 3: saturate and apply sign; NaN gives zero, unconverted components pass raw bits
	vcfc_out_t res_c;
	always_comb begin
		res_c.result_bits = raw_s2;
		res_c.out_of_range = 1'b0;
		if (conv_s2) begin
			if (nan_s2) begin
				res_c.result_bits = '0;
				res_c.out_of_range = 1'b1;
			end else if (!sign_s2) begin
				if (inf_s2 || sat_s2 || mag_s2[31]) begin
					res_c.result_bits = INT_MAX_BITS;
					res_c.out_of_range = 1'b1;
				end else begin
					res_c.result_bits = mag_s2;
				end
			end else begin
				if (inf_s2 || sat_s2 || (mag_s2[31] && mag_s2[30:0] != '0)) begin
					res_c.result_bits = INT_MIN_BITS;
					res_c.out_of_range = 1'b1;
				end else begin
					res_c.result_bits = 32'd0 - mag_s2;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s3 <= res_c;
			res_s4 <= res_s3;
		end
	end
endmodule

// File: src/vcfc_checker.sv
// vcfc_checker: port-level assertions for vertex_component_float_convert_core
// depends on vcfc_pkg and the channel interfaces; bound to the top level below
module vcfc_checker import vcfc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input vcfc_out_t out_payload
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("stalled result changed");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked while output empty");
	a_nan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_payload.out_of_range |->
		out_payload.result_bits == '0 || out_payload.result_bits == INT_MAX_BITS
		|| out_payload.result_bits == INT_MIN_BITS)
		else $error("flagged result not a saturation or zero");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready ##1 out_ready
		|=> out_valid)
		else $error("item lost in pipeline");
endmodule

bind vertex_component_float_convert_core vcfc_checker u_vcfc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_payload(out_ch.payload)
);
